FILE: design/bse_pkg.sv
// shared constants and types for the binned sample entropy block
package bse_pkg;

  localparam int COUNT_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 24;
  localparam int SUM_BITS   = 64;
  localparam int LOG_BITS   = 38;  // 6 exponent bits, 32 fraction bits
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = 2;
  localparam logic [24:0] LN2_Q25 = 25'd23258160;
  localparam int RSHIFT     = 57 - FRAC_BITS;
  localparam logic [OUT_BITS-1:0] POS_MAX = 24'h7FFFFF;
  localparam logic [OUT_BITS:0]   NEG_MAX = 25'h0800000;

  typedef logic [SUM_BITS-1:0] sum_t;

  // one closed bin handed from the front to the back
  typedef struct packed {
    sum_t bin_a;
    sum_t bin_b;
    sum_t file_a;
    sum_t file_b;
    logic bin_valid;
    logic file_valid;
    logic file_end;
  } bse_job_t;

  function automatic sum_t sat_add(sum_t a, sum_t b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
  endfunction

endpackage

FILE: design/binned_sample_entropy_core.sv
// top level of the binned sample entropy block
// Usage:
//   Input channel: one item per transfer (in_valid_i / in_stall_o) carrying a
//   pair of pattern counts and bin/file close flags. Items that do not close a
//   bin are absorbed at one per cycle while in_stall_o is low, by a three-stage
//   accumulate pipeline. Output channel: one result per closed bin or file end
//   (out_valid_o / out_stall_i) with the bin log ratio and, at file end, the
//   file log ratio, both signed Q8.16. A close is pushed into the queue from
//   the accumulate stage; the back end finds each log2 by normalize shifts (one
//   normalize shift per cycle), 32 squarings and one difference step, then
//   multiplies and rounds each ratio. When neither ratio is due, the back end
//   goes straight to rounding and output.
//   Throughput is one item per cycle while in_stall_o is low, set by the single
//   adder per sum; close rate is set by the shared one-bit-per-cycle log2 unit.
//   The queue holds closed bins so input keeps flowing while the log unit works;
//   once two jobs wait, in_stall_o rises.
//   Reset clears all sums, the queue pointers and the output valid flag.
//   When the receiver stalls, the result holds and the back end waits.
module binned_sample_entropy_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] count_m_i,
  input  logic        has_count_m_i,
  input  logic [31:0] count_m1_i,
  input  logic        counts_valid_i,
  input  logic        last_in_bin_i,
  input  logic        last_in_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] bin_entropy_o,
  output logic        bin_valid_o,
  output logic [23:0] file_entropy_o,
  output logic        file_valid_o,
  output logic        file_end_o
);
  import bse_pkg::*;

  bse_job_t f_job, q_job;
  logic f_push, q_full, q_valid, q_pop;

  bse_front u_front (
    .clk_i, .rst_ni,
    .count_m_i, .has_count_m_i, .count_m1_i, .counts_valid_i,
    .last_in_bin_i, .last_in_file_i,
    .in_valid_i, .in_stall_o,
    .job_valid_o(f_push), .job_o(f_job), .job_full_i(q_full)
  );

  bse_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(f_push), .push_data_i(f_job), .full_o(q_full),
    .pop_valid_o(q_valid), .pop_data_o(q_job), .pop_i(q_pop)
  );

  bse_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_i(q_job), .job_pop_o(q_pop),
    .bin_entropy_o, .bin_valid_o, .file_entropy_o, .file_valid_o, .file_end_o,
    .out_valid_o, .out_stall_i
  );

endmodule

FILE: design/bse_front.sv
// front end: accumulates pair counts per bin and per file, emits closed-bin jobs
module bse_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bse_pkg::COUNT_BITS-1:0] count_m_i,
  input  logic                          has_count_m_i,
  input  logic [bse_pkg::COUNT_BITS-1:0] count_m1_i,
  input  logic                          counts_valid_i,
  input  logic                          last_in_bin_i,
  input  logic                          last_in_file_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic                          job_valid_o,
  output bse_pkg::bse_job_t             job_o,
  input  logic                          job_full_i
);
  import bse_pkg::*;

  // stage 1: register counts; stage 2: pair products; stage 3: accumulate
  logic                  s1_v_q, s2_v_q;
  logic [COUNT_BITS-1:0] s1_cm_q, s1_cm1_q;
  logic                  s1_hm_q, s1_cv_q, s1_lb_q, s1_lf_q;
  sum_t                  s2_pm_q, s2_pm1_q;
  logic                  s2_lb_q, s2_lf_q;
  sum_t bin_a_q, bin_b_q, file_a_q, file_b_q;
  logic       stall;
  logic [2*COUNT_BITS-1:0] pm, pm1;
  sum_t na, nb, fa, fb;
  logic bv, fv, close;

  // stall while the queue may lack room for items already in flight
  assign stall      = job_full_i;
  assign in_stall_o = stall;

  assign pm  = ({{COUNT_BITS{1'b0}}, s1_cm_q} * {{COUNT_BITS{1'b0}}, s1_cm_q - 1'b1}) >> 1;
  assign pm1 = ({{COUNT_BITS{1'b0}}, s1_cm1_q} * {{COUNT_BITS{1'b0}}, s1_cm1_q - 1'b1}) >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_valid_i & ~stall;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cm_q  <= count_m_i;
    s1_cm1_q <= count_m1_i;
    s1_hm_q  <= has_count_m_i;
    s1_cv_q  <= counts_valid_i;
    s1_lb_q  <= last_in_bin_i;
    s1_lf_q  <= last_in_file_i;
    s2_pm_q  <= (s1_cv_q && s1_hm_q && s1_cm_q > 1) ? sum_t'(pm) : '0;
    s2_pm1_q <= (s1_cv_q && s1_cm1_q > 1) ? sum_t'(pm1) : '0;
    s2_lb_q  <= s1_lb_q;
    s2_lf_q  <= s1_lf_q;
  end

  always_comb begin
    na    = sat_add(bin_a_q, s2_pm_q);
    nb    = sat_add(bin_b_q, s2_pm1_q);
    bv    = (na != '0) && (nb != '0);
    fa    = bv ? sat_add(file_a_q, na) : file_a_q;
    fb    = bv ? sat_add(file_b_q, nb) : file_b_q;
    fv    = (fa != '0) && (fb != '0);
    close = s2_v_q & (s2_lb_q | s2_lf_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_a_q  <= '0;
      bin_b_q  <= '0;
      file_a_q <= '0;
      file_b_q <= '0;
    end else if (s2_v_q) begin
      if (close) begin
        bin_a_q <= '0;
        bin_b_q <= '0;
        file_a_q <= s2_lf_q ? '0 : fa;
        file_b_q <= s2_lf_q ? '0 : fb;
      end else begin
        bin_a_q <= na;
        bin_b_q <= nb;
      end
    end
  end

  assign job_valid_o     = close;
  assign job_o.bin_a     = na;
  assign job_o.bin_b     = nb;
  assign job_o.file_a    = fa;
  assign job_o.file_b    = fb;
  assign job_o.bin_valid = bv;
  assign job_o.file_valid = s2_lf_q & fv;
  assign job_o.file_end  = s2_lf_q;

endmodule

FILE: design/bse_queue.sv
// small job queue between front and back
module bse_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bse_pkg::bse_job_t push_data_i,
  output logic              full_o,
  output logic              pop_valid_o,
  output bse_pkg::bse_job_t pop_data_o,
  input  logic              pop_i
);
  import bse_pkg::*;

  bse_job_t mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QPTR_BITS:0]   cnt_q;

  // two pipeline stages may still deliver jobs after stall rises
  assign full_o      = cnt_q >= (QPTR_BITS+1)'(QDEPTH - 2);
  assign pop_valid_o = cnt_q != '0;
  assign pop_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPTR_BITS+1)'(push_i) - (QPTR_BITS+1)'(pop_i);
    end
  end

endmodule

FILE: design/bse_back.sv
// back end: iterative log2 unit computing ln(a/b) for bin and file, output register
module bse_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  bse_pkg::bse_job_t           job_i,
  output logic                        job_pop_o,
  output logic [bse_pkg::OUT_BITS-1:0] bin_entropy_o,
  output logic                        bin_valid_o,
  output logic [bse_pkg::OUT_BITS-1:0] file_entropy_o,
  output logic                        file_valid_o,
  output logic                        file_end_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i
);
  import bse_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_SQ, S_MUL, S_RND, S_DONE
  } state_e;

  state_e state_q;
  logic [1:0] op_q;        // 0 bin a, 1 bin b, 2 file a, 3 file b
  sum_t       x_q;
  logic [5:0] e_q, i_q;
  logic [31:0] m_q, f_q;
  logic [LOG_BITS-1:0] la_q;
  logic        neg_q;
  logic [LOG_BITS-1:0] mag_q;
  logic [63:0] prod_q;
  logic [OUT_BITS-1:0] bres_q;
  logic [63:0] sq;
  logic [LOG_BITS-1:0] lcur;
  logic [63:0] rnd;
  logic [OUT_BITS-1:0] res;
  logic last_op;
  sum_t src;

  assign sq   = {32'd0, m_q} * {32'd0, m_q};
  assign lcur = {e_q, f_q};
  assign last_op = (op_q == 2'd1 && !(job_i.file_end && job_i.file_valid)) || op_q == 2'd3;

  always_comb begin
    unique case (op_q)
      2'd0:    src = job_i.bin_a;
      2'd1:    src = job_i.bin_b;
      2'd2:    src = job_i.file_a;
      default: src = job_i.file_b;
    endcase
    rnd = (prod_q + (64'd1 << (RSHIFT - 1))) >> RSHIFT;
    if (neg_q) begin
      res = (rnd > {39'd0, NEG_MAX}) ? NEG_MAX[OUT_BITS-1:0] : OUT_BITS'(~rnd + 64'd1);
    end else begin
      res = (rnd > {40'd0, POS_MAX}) ? POS_MAX : rnd[OUT_BITS-1:0];
    end
  end

  assign job_pop_o = (state_q == S_RND) && last_op && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      op_q        <= '0;
    end else begin
      if (job_pop_o) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            if (job_i.bin_valid) begin
              op_q <= 2'd0;
              state_q <= S_NORM;
            end else if (job_i.file_end && job_i.file_valid) begin
              bres_q <= '0;
              op_q <= 2'd2;
              state_q <= S_NORM;
            end else begin
              bres_q <= '0;
              neg_q  <= 1'b0;
              prod_q <= '0;
              op_q   <= 2'd3;
              state_q <= S_RND;
            end
            x_q <= '0;
          end
        end
        S_NORM: begin
          // leading-one search, one bit per cycle
          if (x_q == '0) begin
            x_q <= src;
            e_q <= 6'd63;
          end else if (!x_q[SUM_BITS-1]) begin
            x_q <= x_q << 1;
            e_q <= e_q - 1'b1;
          end else begin
            m_q <= x_q[63:32];
            i_q <= '0;
            f_q <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          f_q <= {f_q[30:0], sq[63]};
          m_q <= sq[63] ? sq[63:32] : sq[62:31];
          i_q <= i_q + 1'b1;
          if (i_q == 6'd31) state_q <= S_MUL;
        end
        S_MUL: begin
          if (!op_q[0]) begin
            la_q <= lcur;
            op_q <= op_q + 1'b1;
            x_q <= '0;
            state_q <= S_NORM;
          end else begin
            neg_q <= la_q < lcur;
            mag_q <= (la_q < lcur) ? lcur - la_q : la_q - lcur;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          prod_q <= {26'd0, mag_q} * {39'd0, LN2_Q25};
          state_q <= S_RND;
        end
        S_RND: begin
          if (!last_op) begin
            bres_q <= res;
            op_q <= 2'd2;
            x_q <= '0;
            state_q <= S_NORM;
          end else if (!out_valid_o || !out_stall_i) begin
            bin_entropy_o  <= (op_q == 2'd1) ? res : bres_q;
            file_entropy_o <= (op_q == 2'd3 && job_i.file_end && job_i.file_valid) ? res : '0;
            bin_valid_o    <= job_i.bin_valid;
            file_valid_o   <= job_i.file_end & job_i.file_valid;
            file_end_o     <= job_i.file_end;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
